@@ design/mkpd_pkg.sv @@
// mkpd_pkg: shared types and constants of the press duration classifier
// no dependencies
`timescale 1ns / 1ps

package mkpd_pkg;

    // field widths
    localparam int POS_BITS   = 6;
    localparam int POS_REG_W  = 36;
    localparam int THR_W      = 32;
    localparam int STATUS_W   = 64;
    localparam int IN_TIME_W  = 32;
    localparam int KIND_W     = 2;
    localparam int SWNUM_W    = 3;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W  = 2;

    // event slots per switch in the queue entry
    localparam int EV_PER_SW  = 3;
    localparam int SLOT_SHORT = 0;
    localparam int SLOT_FIRST = 1;
    localparam int SLOT_HIGH  = 2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_THIRD  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_POSITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_HOLD    = 2'd3;

    // configuration reset values
    localparam logic [POS_REG_W-1:0] RST_BIT_POSITIONS = 36'd5436612672;
    localparam logic [THR_W-1:0]     RST_FIRST_HOLD    = 32'd5000;
    localparam logic [THR_W-1:0]     RST_SECOND_HOLD   = 32'd10000;
    localparam logic [THR_W-1:0]     RST_THIRD_HOLD    = 32'd15000;

    typedef struct packed {
        logic [POS_REG_W-1:0] bit_positions;
        logic [THR_W-1:0]     first_hold_ms;
        logic [THR_W-1:0]     second_hold_ms;
        logic [THR_W-1:0]     third_hold_ms;
    } t_cfg;

endpackage

@@ design/mkpd_front.sv @@
// mkpd_front: per switch press tracking and threshold checks for one scan
// depends on mkpd_pkg
`timescale 1ns / 1ps

module mkpd_front #(
    parameter int NUM_SWITCHES = 6,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  mkpd_pkg::t_cfg                               i_cfg,
    input  logic                                         i_accept,
    input  logic [mkpd_pkg::STATUS_W-1:0]                i_raw_status,
    input  logic [mkpd_pkg::IN_TIME_W-1:0]               i_time_ms,
    output logic [NUM_SWITCHES*mkpd_pkg::EV_PER_SW-1:0]  o_events
);

    localparam int CMP_W = (TIME_WIDTH > mkpd_pkg::THR_W) ? TIME_WIDTH : mkpd_pkg::THR_W;

    logic [TIME_WIDTH-1:0] w_now;

    // current time reduced to the tracking width
    assign w_now = TIME_WIDTH'(i_time_ms);

    for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_sw
        logic [mkpd_pkg::POS_BITS-1:0] w_pos;
        logic                          w_touched;
        logic                          w_press;
        logic                          w_release;
        logic                          w_hold;
        logic [TIME_WIDTH-1:0]         w_held;
        logic                          w_fire1;
        logic                          w_fire2;
        logic                          w_fire3;
        logic                          r_was_pressed;
        logic [TIME_WIDTH-1:0]         r_press_start;
        logic                          r_first_fired;
        logic                          r_second_fired;
        logic                          r_third_fired;

        // status bit position, fields above the register read as zero
        if ((s + 1) * mkpd_pkg::POS_BITS <= mkpd_pkg::POS_REG_W) begin : g_pos
            assign w_pos = i_cfg.bit_positions[s*mkpd_pkg::POS_BITS +: mkpd_pkg::POS_BITS];
        end else begin : g_pos_zero
            assign w_pos = '0;
        end

        assign w_touched = i_raw_status[w_pos];
        assign w_press   = w_touched & ~r_was_pressed;
        assign w_release = ~w_touched & r_was_pressed;
        assign w_hold    = w_touched & r_was_pressed;

        // elapsed time and threshold checks
        assign w_held  = w_now - r_press_start;
        assign w_fire1 = w_hold & ~r_first_fired
                       & (CMP_W'(w_held) >= CMP_W'(i_cfg.first_hold_ms));
        assign w_fire2 = w_hold & ~r_second_fired
                       & (CMP_W'(w_held) >= CMP_W'(i_cfg.second_hold_ms));
        assign w_fire3 = w_hold & ~r_third_fired
                       & (CMP_W'(w_held) >= CMP_W'(i_cfg.third_hold_ms));

        // reported events of this switch
        assign o_events[s*mkpd_pkg::EV_PER_SW + mkpd_pkg::SLOT_SHORT] =
            w_release & ~(r_first_fired | r_second_fired | r_third_fired);
        assign o_events[s*mkpd_pkg::EV_PER_SW + mkpd_pkg::SLOT_FIRST] = w_fire1;
        assign o_events[s*mkpd_pkg::EV_PER_SW + mkpd_pkg::SLOT_HIGH]  =
            (s == 0) ? w_fire3 : w_fire2;

        // press state update
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_was_pressed  <= 1'b0;
                r_press_start  <= '0;
                r_first_fired  <= 1'b0;
                r_second_fired <= 1'b0;
                r_third_fired  <= 1'b0;
            end else if (i_accept) begin
                r_was_pressed <= w_touched;
                if (w_press) begin
                    r_press_start  <= w_now;
                    r_first_fired  <= 1'b0;
                    r_second_fired <= 1'b0;
                    r_third_fired  <= 1'b0;
                end else begin
                    r_first_fired  <= r_first_fired  | w_fire1;
                    r_second_fired <= r_second_fired | w_fire2;
                    r_third_fired  <= r_third_fired  | w_fire3;
                end
            end
        end
    end

endmodule

@@ design/mkpd_queue.sv @@
// mkpd_queue: small fifo of per scan event masks between front and back
// no dependencies
`timescale 1ns / 1ps

module mkpd_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/mkpd_back.sv @@
// mkpd_back: turns one queued event mask into events, one per cycle while i_out_ready is high
// depends on mkpd_pkg
`timescale 1ns / 1ps

module mkpd_back #(
    parameter int NUM_SWITCHES = 6
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_q_empty,
    input  logic [NUM_SWITCHES*mkpd_pkg::EV_PER_SW-1:0]  i_q_data,
    output logic                                         o_q_pop,
    output logic                                         o_out_valid,
    input  logic                                         i_out_ready,
    output logic [mkpd_pkg::KIND_W-1:0]                  o_event_kind,
    output logic [mkpd_pkg::SWNUM_W-1:0]                 o_switch_number,
    output logic                                         o_last_event
);

    localparam int W = NUM_SWITCHES * mkpd_pkg::EV_PER_SW;

    logic [W-1:0]                 r_pend;
    logic [W-1:0]                 w_low;
    logic [mkpd_pkg::SWNUM_W-1:0] w_sel_sw;
    logic [1:0]                   w_sel_slot;
    logic                         w_fire;
    logic                         w_done;

    // lowest pending event in switch order
    assign w_low = r_pend & (~r_pend + 1'b1);

    always_comb begin
        w_sel_sw   = '0;
        w_sel_slot = '0;
        for (int s = NUM_SWITCHES - 1; s >= 0; s--) begin
            for (int k = mkpd_pkg::EV_PER_SW - 1; k >= 0; k--) begin
                if (r_pend[s*mkpd_pkg::EV_PER_SW + k]) begin
                    w_sel_sw   = mkpd_pkg::SWNUM_W'(s);
                    w_sel_slot = 2'(k);
                end
            end
        end
    end

    // event fields
    always_comb begin
        case (w_sel_slot)
            2'(mkpd_pkg::SLOT_SHORT): o_event_kind = mkpd_pkg::KIND_SHORT;
            2'(mkpd_pkg::SLOT_FIRST): o_event_kind = mkpd_pkg::KIND_FIRST;
            2'(mkpd_pkg::SLOT_HIGH):  o_event_kind = (w_sel_sw == '0) ? mkpd_pkg::KIND_THIRD
                                                                      : mkpd_pkg::KIND_SECOND;
            default:                  o_event_kind = mkpd_pkg::KIND_SHORT;
        endcase
    end

    assign o_switch_number = w_sel_sw + 1'b1;
    assign o_last_event    = ((r_pend & ~w_low) == '0);
    assign o_out_valid     = |r_pend;

    // load the next mask once the current one is drained
    assign w_fire  = o_out_valid & i_out_ready;
    assign w_done  = ~o_out_valid | (w_fire & o_last_event);
    assign o_q_pop = w_done & ~i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (o_q_pop) begin
            r_pend <= i_q_data;
        end else if (w_fire) begin
            r_pend <= r_pend & ~w_low;
        end
    end

endmodule

@@ design/multi_key_press_duration_classifier_core.sv @@
// multi_key_press_duration_classifier_core: top level of the press classifier
// depends on mkpd_pkg, mkpd_front, mkpd_queue, mkpd_back
`timescale 1ns / 1ps

// Classifies presses of up to NUM_SWITCHES touch switches from a stream of scan
// transactions. A scan is taken whenever the two-entry event queue has room; the
// front updates all switch states in that cycle and queues the scan's events as
// one mask, scans without events queue nothing. The back hands out one event per
// cycle while i_out_ready is high, in switch order, with o_last_event on the final
// event of a scan; a scan with n events takes n transfers (up to 12 at six switches)
// and further scans are taken while earlier events drain. Configuration writes are
// registered; the user must write them only while idle, the block does not check.
module multi_key_press_duration_classifier_core #(
    parameter int NUM_SWITCHES = 6,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mkpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mkpd_pkg::STATUS_W-1:0]     i_raw_status,
    input  logic [mkpd_pkg::IN_TIME_W-1:0]    i_time_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mkpd_pkg::KIND_W-1:0]       o_event_kind,
    output logic [mkpd_pkg::SWNUM_W-1:0]      o_switch_number,
    output logic                              o_last_event
);

    localparam int EV_W = NUM_SWITCHES * mkpd_pkg::EV_PER_SW;

    mkpd_pkg::t_cfg r_cfg;
    logic           w_accept;
    logic [EV_W-1:0] w_events;
    logic            w_push;
    logic [EV_W-1:0] w_q_data;
    logic            w_q_full;
    logic            w_q_empty;
    logic            w_q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_positions  <= mkpd_pkg::RST_BIT_POSITIONS;
            r_cfg.first_hold_ms  <= mkpd_pkg::RST_FIRST_HOLD;
            r_cfg.second_hold_ms <= mkpd_pkg::RST_SECOND_HOLD;
            r_cfg.third_hold_ms  <= mkpd_pkg::RST_THIRD_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mkpd_pkg::CFG_BIT_POSITIONS: r_cfg.bit_positions <=
                    i_cfg_data[mkpd_pkg::POS_REG_W-1:0];
                mkpd_pkg::CFG_FIRST_HOLD:    r_cfg.first_hold_ms <=
                    i_cfg_data[mkpd_pkg::THR_W-1:0];
                mkpd_pkg::CFG_SECOND_HOLD:   r_cfg.second_hold_ms <=
                    i_cfg_data[mkpd_pkg::THR_W-1:0];
                mkpd_pkg::CFG_THIRD_HOLD:    r_cfg.third_hold_ms <=
                    i_cfg_data[mkpd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // scan transaction accepted while the queue has room
    assign o_in_ready = ~w_q_full;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_push     = w_accept & (|w_events);

    mkpd_front #(
        .NUM_SWITCHES (NUM_SWITCHES),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_raw_status (i_raw_status),
        .i_time_ms    (i_time_ms),
        .o_events     (w_events)
    );

    mkpd_queue #(
        .WIDTH (EV_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_events),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    mkpd_back #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_q_data),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_kind    (o_event_kind),
        .o_switch_number (o_switch_number),
        .o_last_event    (o_last_event)
    );

    // checks
    a_third_only_switch1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == mkpd_pkg::KIND_THIRD) |-> (o_switch_number == 3'd1))
        else $error("third long press reported for a switch other than 1");

    a_switch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && NUM_SWITCHES < 8) |->
        (o_switch_number >= 3'd1 && o_switch_number <= 3'(NUM_SWITCHES)))
        else $error("switch number out of range");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("event presented right after reset");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("event mask queued while the queue is full");

endmodule

@@ dv/mkpd_checker.sv @@
// mkpd_checker: scoreboard for the press duration classifier
// watches the config port and both channels, predicts events per scan and compares them
// depends on mkpd_pkg
`timescale 1ns / 1ps

module mkpd_checker #(
    parameter int NUM_SWITCHES = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mkpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mkpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [mkpd_pkg::STATUS_W-1:0]    i_raw_status,
    input  logic [mkpd_pkg::IN_TIME_W-1:0]   i_time_ms,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [mkpd_pkg::KIND_W-1:0]      i_event_kind,
    input  logic [mkpd_pkg::SWNUM_W-1:0]     i_switch_number,
    input  logic                             i_last_event,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_events_seen
);

    typedef struct packed {
        logic [mkpd_pkg::KIND_W-1:0]  kind;
        logic [mkpd_pkg::SWNUM_W-1:0] sw_num;
        logic                         last;
    } t_press_event;

    // shadow copy of the registers and of the per-switch press state
    mkpd_pkg::t_cfg               cfg;
    logic                         pressed      [NUM_SWITCHES];
    logic [mkpd_pkg::THR_W-1:0]   start_ms     [NUM_SWITCHES];
    logic                         fired_first  [NUM_SWITCHES];
    logic                         fired_second [NUM_SWITCHES];
    logic                         fired_third  [NUM_SWITCHES];
    t_press_event                 pending_events[$];

    // classify one scan and queue the events it produces, in switch order
    task automatic classify_scan(input logic [mkpd_pkg::STATUS_W-1:0] status,
                                 input logic [mkpd_pkg::IN_TIME_W-1:0] now);
        t_press_event                   scan_events[$];
        logic                           touched;
        logic [mkpd_pkg::IN_TIME_W-1:0] held_ms;
        logic [mkpd_pkg::POS_BITS-1:0]  pos;
        logic [mkpd_pkg::SWNUM_W-1:0]   sw_num;
        for (int s = 0; s < NUM_SWITCHES; s++) begin
            // fields above the 36-bit register read as zero
            pos     = mkpd_pkg::POS_BITS'(cfg.bit_positions >> (s * mkpd_pkg::POS_BITS));
            touched = status[pos];
            sw_num  = mkpd_pkg::SWNUM_W'(s + 1);
            if (touched && !pressed[s]) begin
                start_ms[s]     = now;
                fired_first[s]  = 1'b0;
                fired_second[s] = 1'b0;
                fired_third[s]  = 1'b0;
            end else if (!touched && pressed[s]) begin
                // short press only if nothing fired, reported or not
                if (!fired_first[s] && !fired_second[s] && !fired_third[s])
                    scan_events.push_back('{kind: mkpd_pkg::KIND_SHORT, sw_num: sw_num,
                                            last: 1'b0});
            end else if (touched) begin
                held_ms = now - start_ms[s];
                if (!fired_first[s] && held_ms >= cfg.first_hold_ms) begin
                    fired_first[s] = 1'b1;
                    scan_events.push_back('{kind: mkpd_pkg::KIND_FIRST, sw_num: sw_num,
                                            last: 1'b0});
                end
                // second long press is silent for switch 1
                if (!fired_second[s] && held_ms >= cfg.second_hold_ms) begin
                    fired_second[s] = 1'b1;
                    if (s != 0)
                        scan_events.push_back('{kind: mkpd_pkg::KIND_SECOND, sw_num: sw_num,
                                                last: 1'b0});
                end
                // third long press is reported for switch 1 only
                if (!fired_third[s] && held_ms >= cfg.third_hold_ms) begin
                    fired_third[s] = 1'b1;
                    if (s == 0)
                        scan_events.push_back('{kind: mkpd_pkg::KIND_THIRD, sw_num: sw_num,
                                                last: 1'b0});
                end
            end
            pressed[s] = touched;
        end
        if (scan_events.size() > 0)
            scan_events[scan_events.size() - 1].last = 1'b1;
        foreach (scan_events[k])
            pending_events.push_back(scan_events[k]);
    endtask

    // register tracking, prediction on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_press_event seen;
        t_press_event want;
        if (!i_rst_n) begin
            cfg = '{bit_positions:  mkpd_pkg::RST_BIT_POSITIONS,
                    first_hold_ms:  mkpd_pkg::RST_FIRST_HOLD,
                    second_hold_ms: mkpd_pkg::RST_SECOND_HOLD,
                    third_hold_ms:  mkpd_pkg::RST_THIRD_HOLD};
            for (int s = 0; s < NUM_SWITCHES; s++) begin
                pressed[s]      = 1'b0;
                start_ms[s]     = '0;
                fired_first[s]  = 1'b0;
                fired_second[s] = 1'b0;
                fired_third[s]  = 1'b0;
            end
            pending_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mkpd_pkg::CFG_BIT_POSITIONS:
                        cfg.bit_positions  = i_cfg_data[mkpd_pkg::POS_REG_W-1:0];
                    mkpd_pkg::CFG_FIRST_HOLD:
                        cfg.first_hold_ms  = i_cfg_data[mkpd_pkg::THR_W-1:0];
                    mkpd_pkg::CFG_SECOND_HOLD:
                        cfg.second_hold_ms = i_cfg_data[mkpd_pkg::THR_W-1:0];
                    mkpd_pkg::CFG_THIRD_HOLD:
                        cfg.third_hold_ms  = i_cfg_data[mkpd_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                classify_scan(i_raw_status, i_time_ms);
            if (i_out_valid && i_out_ready) begin
                seen = '{kind: i_event_kind, sw_num: i_switch_number, last: i_last_event};
                o_events_seen++;
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, %s",
                             $time, "actual:");
                    $display("    kind=%0d sw=%0d last=%0d",
                             seen.kind, seen.sw_num, seen.last);
                    o_fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (seen !== want) begin
                        $display("%0t: event mismatch, expected kind=%0d sw=%0d last=%0d,",
                                 $time, want.kind, want.sw_num, want.last);
                        $display("    actual kind=%0d sw=%0d last=%0d",
                                 seen.kind, seen.sw_num, seen.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pending_events.size();
    end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus and verdict for the press duration classifier
// depends on mkpd_pkg, multi_key_press_duration_classifier_core and mkpd_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SW       = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [mkpd_pkg::IN_TIME_W-1:0] NEAR_WRAP = 32'hFFFF_F000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [mkpd_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [mkpd_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [mkpd_pkg::STATUS_W-1:0]    i_raw_status;
    logic [mkpd_pkg::IN_TIME_W-1:0]   i_time_ms;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [mkpd_pkg::KIND_W-1:0]      o_event_kind;
    logic [mkpd_pkg::SWNUM_W-1:0]     o_switch_number;
    logic                             o_last_event;

    int fail_count;
    int pending;
    int events_seen;
    int cycle_count;
    int scans_sent;
    int reg_writes;
    int src_gap_max;
    int sink_stall_max;

    // stimulus view of the switches
    logic [mkpd_pkg::POS_REG_W-1:0]   cur_positions;
    logic [mkpd_pkg::IN_TIME_W-1:0]   now_ms;
    logic [mkpd_pkg::IN_TIME_W-1:0]   step_span;
    logic [NUM_SW-1:0]                held_sw;

    multi_key_press_duration_classifier_core #(
        .NUM_SWITCHES(NUM_SW),
        .TIME_WIDTH  (mkpd_pkg::IN_TIME_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_raw_status   (i_raw_status),
        .i_time_ms      (i_time_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_switch_number(o_switch_number),
        .o_last_event   (o_last_event)
    );

    mkpd_checker #(
        .NUM_SWITCHES(NUM_SW)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_raw_status   (i_raw_status),
        .i_time_ms      (i_time_ms),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_kind   (o_event_kind),
        .i_switch_number(o_switch_number),
        .i_last_event   (o_last_event),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_events_seen  (events_seen)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall before taking each transaction
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one register write, blocked while the classifier is busy by the callers
    task automatic write_reg(input logic [mkpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mkpd_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        if (idx == mkpd_pkg::CFG_BIT_POSITIONS)
            cur_positions = data[mkpd_pkg::POS_REG_W-1:0];
    endtask

    // send one scan transaction after a random gap
    task automatic send_scan(input logic [mkpd_pkg::STATUS_W-1:0] status,
                             input logic [mkpd_pkg::IN_TIME_W-1:0] t);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_status <= status;
        i_time_ms    <= t;
        do @(posedge i_clk); while (!o_in_ready);
        scans_sent++;
    endtask

    task automatic scan_at(input logic [mkpd_pkg::STATUS_W-1:0] status,
                           input logic [mkpd_pkg::IN_TIME_W-1:0] delta);
        now_ms = now_ms + delta;
        send_scan(status, now_ms);
    endtask

    // hold off the sender until every expected event has left
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [mkpd_pkg::POS_REG_W-1:0] positions,
                              input logic [mkpd_pkg::THR_W-1:0] t1,
                              input logic [mkpd_pkg::THR_W-1:0] t2,
                              input logic [mkpd_pkg::THR_W-1:0] t3);
        wait_idle();
        write_reg(mkpd_pkg::CFG_BIT_POSITIONS, mkpd_pkg::CFG_DATA_W'(positions));
        write_reg(mkpd_pkg::CFG_FIRST_HOLD, mkpd_pkg::CFG_DATA_W'(t1));
        write_reg(mkpd_pkg::CFG_SECOND_HOLD, mkpd_pkg::CFG_DATA_W'(t2));
        write_reg(mkpd_pkg::CFG_THIRD_HOLD, mkpd_pkg::CFG_DATA_W'(t3));
    endtask

    // status word with the given switches touched and random bits elsewhere
    function automatic logic [mkpd_pkg::STATUS_W-1:0] scan_word(input logic [NUM_SW-1:0] touch);
        logic [mkpd_pkg::STATUS_W-1:0] w;
        logic [mkpd_pkg::POS_BITS-1:0] pos;
        w = {$urandom, $urandom};
        for (int s = 0; s < NUM_SW; s++) begin
            pos    = mkpd_pkg::POS_BITS'(cur_positions >> (s * mkpd_pkg::POS_BITS));
            w[pos] = touch[s];
        end
        return w;
    endfunction

    // time advance: mostly within the phase span, some zero steps, some wrapping jumps
    function automatic logic [mkpd_pkg::IN_TIME_W-1:0] time_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom;
        if (r < 15)
            return '0;
        return $urandom_range(0, step_span);
    endfunction

    // press/release sequences with random content, plus some raw noise scans
    task automatic run_random(input int n);
        logic [mkpd_pkg::STATUS_W-1:0] status;
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                wait_idle();
            if (r < 88) begin
                for (int s = 0; s < NUM_SW; s++)
                    if ($urandom_range(0, 3) == 0)
                        held_sw[s] = ~held_sw[s];
                status = scan_word(held_sw);
            end else begin
                status = {$urandom, $urandom};
            end
            scan_at(status, time_step());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = mkpd_pkg::CFG_BIT_POSITIONS;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_raw_status   = '0;
        i_time_ms      = '0;
        cur_positions  = mkpd_pkg::RST_BIT_POSITIONS;
        now_ms         = '0;
        held_sw        = '0;
        step_span      = 32'd6000;
        src_gap_max    = 8;
        sink_stall_max = 8;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, switch k on status bit k-1
        scan_at('0, 0);
        now_ms = NEAR_WRAP;
        scan_at('1, 0);                         // every switch pressed
        scan_at('1, 32'd4999);                  // held just under, across the wrap
        scan_at('1, 32'd1);                     // first long for all
        scan_at('1, 32'd10000);                 // second and third together
        scan_at(64'hFFFF_FFFF_FFFF_FFC0, 32'd1000); // release, nothing since flags fired
        scan_at(64'h5, 32'd100);
        scan_at(64'h0, 32'd50);                 // short presses on switches 1 and 3
        scan_at(64'h3F, 32'd7);
        scan_at(64'h3F, 32'd20000);             // all thresholds in one scan, twelve events
        scan_at(64'h0, 32'd10);
        scan_at(64'h1, 32'd10);
        scan_at(64'h1, 32'd10000);              // silent second on switch 1
        scan_at(64'h0, 32'd10);                 // no short press after it
        scan_at(64'h2, 32'd10);
        scan_at(64'h2, 32'd15000);              // silent third on switch 2
        scan_at(64'h0, 32'd10);
        run_random(40);

        // zero thresholds, every switch on status bit 0, no idling
        set_config('0, '0, '0, '0);
        src_gap_max    = 0;
        sink_stall_max = 0;
        step_span      = 32'd50;
        scan_at(64'h1, 32'd0);
        scan_at(64'h1, 32'd0);                  // all fire on the first held scan
        scan_at(64'h0, 32'd0);
        run_random(25);

        // random positions, small unordered thresholds
        set_config(mkpd_pkg::POS_REG_W'({$urandom, $urandom}), $urandom_range(0, 2000),
                   $urandom_range(0, 2000), $urandom_range(0, 2000));
        src_gap_max    = 8;
        sink_stall_max = 8;
        step_span      = 32'd1500;
        run_random(50);

        // every switch on status bit 63, extreme thresholds
        set_config('1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1);
        step_span = 32'hFFFF_FFFF;
        scan_at(64'h8000_0000_0000_0000, 32'd0);
        scan_at(64'h8000_0000_0000_0000, 32'hFFFF_FFFF); // largest held time
        scan_at(64'h0, 32'd1);
        scan_at(64'h8000_0000_0000_0000, 32'd1);
        scan_at(64'h8000_0000_0000_0000, 32'd1);         // only the third threshold
        scan_at(64'h0, 32'd1);
        run_random(25);

        // random positions, short ordered thresholds, fast sender and slow receiver
        set_config(mkpd_pkg::POS_REG_W'({$urandom, $urandom}), 32'd300, 32'd600, 32'd900);
        src_gap_max = 0;
        step_span   = 32'd500;
        run_random(40);

        // back to reset values
        set_config(mkpd_pkg::RST_BIT_POSITIONS, mkpd_pkg::RST_FIRST_HOLD,
                   mkpd_pkg::RST_SECOND_HOLD, mkpd_pkg::RST_THIRD_HOLD);
        src_gap_max = 8;
        step_span   = 32'd6000;
        run_random(24);

        wait_idle();
        $display("sent %0d scans and checked %0d events", scans_sent, events_seen);
        $display("under six register settings (%0d writes)", reg_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mkpd_pkg.sv
design/mkpd_front.sv
design/mkpd_queue.sv
design/mkpd_back.sv
design/multi_key_press_duration_classifier_core.sv
dv/mkpd_checker.sv
dv/tb_top.sv
